/* src/assert_macros.svh */
// Assertion macros used by the span generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication in the same cycle, off during reset.
`define CSSG_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("span generator check failed");

// Check a consequence in the next cycle, active during reset too.
`define CSSG_ASSERT_NEXT(label, clk, pre, post) \
   label: assert property (@(posedge clk) (pre) |=> (post)) \
      else $error("span generator check failed");

`endif

/* src/cssg_pkg.sv */
// Shared types, constants and the square root step of the span generator.
package cssg_pkg;

   localparam int SCREEN_WIDTH_DEF  = 480;
   localparam int SCREEN_HEIGHT_DEF = 320;

   localparam int PITCH_W = 13;
   localparam logic [PITCH_W-1:0] PITCH_RESET = 13'd480;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_IDX_LSB = 2;
   localparam logic [CSR_ADDR_W-CSR_IDX_LSB-1:0] CSR_PITCH_IDX = 1'b0;

   localparam logic SHAPE_RECT   = 1'b0;
   localparam logic SHAPE_CIRCLE = 1'b1;

   localparam int SQ_W            = 21;
   localparam int SQRT_STEPS      = 10;
   localparam int STEPS_PER_STAGE = 2;
   localparam int SQRT_STAGES     = SQRT_STEPS / STEPS_PER_STAGE;

   typedef struct packed {
      logic               hit;
      logic               kind;
      logic signed [15:0] ax;
      logic [11:0]        w;
      logic [11:0]        row;
      logic [31:0]        color;
   } side_type;

   typedef struct packed {
      logic [SQ_W-1:0] rem;
      logic [SQ_W-1:0] res;
   } root_type;

   // One digit of the restoring square root, trial bit 4**k.
   function automatic root_type sqrt_step(root_type cur, int unsigned k);
      logic [SQ_W-1:0] bitv;
      logic [SQ_W-1:0] trial;
      root_type        nxt;
      bitv  = SQ_W'(1) << (2 * k);
      trial = cur.res + bitv;
      if (cur.rem >= trial) begin
         nxt.rem = cur.rem - trial;
         nxt.res = (cur.res >> 1) + bitv;
      end else begin
         nxt.rem = cur.rem;
         nxt.res = cur.res >> 1;
      end
      return nxt;
   endfunction

endpackage

/* src/clipped_shape_span_generator_core.sv */
// Top level of the clipped rectangle and circle scanline span generator.
// Stages from an accepted req beat to rsp_valid: 1 decode, 5 root, 2 clip.
// Throughput: one beat per cycle while rsp_ready is high; the square root is fully pipelined, two digits a stage.
// Reset: synchronous, empties every stage and sets pitch_ff to 480.
// Stages advance independently, so bubbles close up while rsp is stalled.
`include "assert_macros.svh"

module clipped_shape_span_generator_core #(
   parameter int SCREEN_WIDTH  = cssg_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = cssg_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_type,
   input  logic signed [15:0]               req_anchor_x,
   input  logic signed [15:0]               req_anchor_y,
   input  logic [11:0]                      req_rect_width,
   input  logic [11:0]                      req_rect_height,
   input  logic [9:0]                       req_radius,
   input  logic [11:0]                      req_row_index,
   input  logic [31:0]                      req_fill_color,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_span_valid,
   output logic [20:0]                      rsp_span_offset,
   output logic [11:0]                      rsp_span_length,
   output logic [31:0]                      rsp_span_color,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [cssg_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [cssg_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [cssg_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);

   logic [cssg_pkg::PITCH_W-1:0]  pitch_ff;
   logic [cssg_pkg::PITCH_W-1:0]  pitch_in;
   logic                          csr_hit;

   logic                p_valid;
   logic                p_ready;
   cssg_pkg::side_type  p_side;
   cssg_pkg::root_type  p_root;
   logic                s_valid;
   logic                s_ready;
   cssg_pkg::side_type  s_side;
   cssg_pkg::root_type  s_root;

   assign csr_hit = (paddr[cssg_pkg::CSR_ADDR_W-1:cssg_pkg::CSR_IDX_LSB]
                     == cssg_pkg::CSR_PITCH_IDX);
   assign pready  = 1'b1;
   assign prdata  = csr_hit ? cssg_pkg::CSR_DATA_W'(pitch_ff) : '0;

   always_comb begin
      pitch_in = pitch_ff;
      if (psel && penable && pwrite && pready && csr_hit) begin
         pitch_in = pwdata[cssg_pkg::PITCH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff <= cssg_pkg::PITCH_RESET;
      end else begin
         pitch_ff <= pitch_in;
      end
   end

   cssg_prep #(
      .SCREEN_HEIGHT(SCREEN_HEIGHT)
   ) u_prep (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .req_type    (req_type),
      .anchor_x    (req_anchor_x),
      .anchor_y    (req_anchor_y),
      .rect_width  (req_rect_width),
      .rect_height (req_rect_height),
      .radius      (req_radius),
      .row_index   (req_row_index),
      .fill_color  (req_fill_color),
      .out_valid   (p_valid),
      .out_ready   (p_ready),
      .out_side    (p_side),
      .out_root    (p_root)
   );

   cssg_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p_valid),
      .in_ready  (p_ready),
      .in_root   (p_root),
      .in_side   (p_side),
      .out_valid (s_valid),
      .out_ready (s_ready),
      .out_root  (s_root),
      .out_side  (s_side)
   );

   cssg_clip #(
      .SCREEN_WIDTH(SCREEN_WIDTH)
   ) u_clip (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s_valid),
      .in_ready    (s_ready),
      .in_root     (s_root),
      .in_side     (s_side),
      .pitch       (pitch_ff),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .span_valid  (rsp_span_valid),
      .span_offset (rsp_span_offset),
      .span_length (rsp_span_length),
      .span_color  (rsp_span_color)
   );

   `CSSG_ASSERT_IMPLY(a_miss_zero, clock, reset, rsp_valid && !rsp_span_valid, rsp_span_offset == '0 && rsp_span_length == '0 && rsp_span_color == '0)
   `CSSG_ASSERT_IMPLY(a_len_on_screen, clock, reset, rsp_valid && rsp_span_valid, 13'(rsp_span_length) <= 13'(SCREEN_WIDTH))
   `CSSG_ASSERT_NEXT(a_reset_empty, clock, reset, !rsp_valid)

endmodule

/* src/cssg_prep.sv */
// Front stage: shape decode, row test and chord radicand i*(2r-i).
module cssg_prep #(
   parameter int SCREEN_HEIGHT = cssg_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic                req_type,
   input  logic signed [15:0]  anchor_x,
   input  logic signed [15:0]  anchor_y,
   input  logic [11:0]         rect_width,
   input  logic [11:0]         rect_height,
   input  logic [9:0]          radius,
   input  logic [11:0]         row_index,
   input  logic [31:0]         fill_color,
   output logic                out_valid,
   input  logic                out_ready,
   output cssg_pkg::side_type  out_side,
   output cssg_pkg::root_type  out_root
);

   localparam logic signed [18:0] ROW_LIMIT = 19'(SCREEN_HEIGHT);

   logic                 v_ff;
   cssg_pkg::side_type   side_ff;
   cssg_pkg::side_type   side_in;
   cssg_pkg::root_type   root_ff;
   cssg_pkg::root_type   root_in;

   logic [10:0]          two_r;
   logic                 is_circle;
   logic                 in_rect;
   logic                 in_circ;
   logic                 in_shape;
   logic signed [18:0]   ay_x;
   logic signed [18:0]   i_x;
   logic signed [18:0]   r_x;
   logic signed [18:0]   row_x;
   logic [10:0]          chord_a;
   logic [10:0]          chord_b;
   logic [21:0]          prod;

   always_comb begin
      two_r     = {radius, 1'b0};
      is_circle = (req_type == cssg_pkg::SHAPE_CIRCLE);
      in_rect   = row_index < rect_height;
      in_circ   = row_index < 12'(two_r);
      in_shape  = is_circle ? in_circ : in_rect;
      ay_x      = 19'(anchor_y);
      i_x       = signed'(19'(row_index));
      r_x       = signed'(19'(radius));
      row_x     = is_circle ? (ay_x - r_x + i_x) : (ay_x + i_x);
      chord_a   = row_index[10:0];
      chord_b   = two_r - row_index[10:0];
      prod      = 22'(chord_a) * 22'(chord_b);

      side_in.hit   = in_shape && !row_x[18] && (row_x < ROW_LIMIT);
      side_in.kind  = req_type;
      side_in.ax    = anchor_x;
      side_in.w     = rect_width;
      side_in.row   = row_x[11:0];
      side_in.color = fill_color;

      root_in.rem = (is_circle && in_circ) ? cssg_pkg::SQ_W'(prod) : '0;
      root_in.res = '0;
   end

   assign in_ready  = !v_ff || out_ready;
   assign out_valid = v_ff;
   assign out_side  = side_ff;
   assign out_root  = root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         side_ff <= side_in;
         root_ff <= root_in;
      end
   end

endmodule

/* src/cssg_sqrt.sv */
// Pipelined integer square root, two digits per stage, sideband carried along.
module cssg_sqrt (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  cssg_pkg::root_type  in_root,
   input  cssg_pkg::side_type  in_side,
   output logic                out_valid,
   input  logic                out_ready,
   output cssg_pkg::root_type  out_root,
   output cssg_pkg::side_type  out_side
);

   localparam int NS  = cssg_pkg::SQRT_STAGES;
   localparam int SPS = cssg_pkg::STEPS_PER_STAGE;

   logic                v_ff    [NS];
   cssg_pkg::root_type  root_ff [NS];
   cssg_pkg::side_type  side_ff [NS];
   cssg_pkg::root_type  root_in [NS];
   logic [NS:0]         rdy;

   assign rdy[NS] = out_ready;

   for (genvar j = 0; j < NS; j++) begin : g_stage
      logic               v_src;
      cssg_pkg::root_type root_src;
      cssg_pkg::side_type side_src;

      if (j == 0) begin : g_head
         assign v_src    = in_valid;
         assign root_src = in_root;
         assign side_src = in_side;
      end else begin : g_body
         assign v_src    = v_ff[j-1];
         assign root_src = root_ff[j-1];
         assign side_src = side_ff[j-1];
      end

      always_comb begin
         cssg_pkg::root_type acc;
         acc = root_src;
         for (int t = 0; t < SPS; t++) begin
            acc = cssg_pkg::sqrt_step(acc, cssg_pkg::SQRT_STEPS - 1 - (j * SPS + t));
         end
         root_in[j] = acc;
      end

      assign rdy[j] = !v_ff[j] || rdy[j+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (rdy[j]) begin
            v_ff[j] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[j] && v_src) begin
            root_ff[j] <= root_in[j];
            side_ff[j] <= side_src;
         end
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = v_ff[NS-1];
   assign out_root  = root_ff[NS-1];
   assign out_side  = side_ff[NS-1];

endmodule

/* src/cssg_clip.sv */
// Back stages: horizontal clip, then word offset and the result register.
module cssg_clip #(
   parameter int SCREEN_WIDTH = cssg_pkg::SCREEN_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  cssg_pkg::root_type            in_root,
   input  cssg_pkg::side_type            in_side,
   input  logic [cssg_pkg::PITCH_W-1:0]  pitch,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic                          span_valid,
   output logic [20:0]                   span_offset,
   output logic [11:0]                   span_length,
   output logic [31:0]                   span_color
);

   localparam logic signed [18:0] COL_LIMIT = 19'(SCREEN_WIDTH);

   typedef struct packed {
      logic        hit;
      logic [14:0] start;
      logic [11:0] len;
      logic [11:0] row;
      logic [31:0] color;
   } clip_type;

   typedef struct packed {
      logic        hit;
      logic [20:0] offset;
      logic [11:0] len;
      logic [31:0] color;
   } span_type;

   logic      va_ff;
   clip_type  clip_ff;
   clip_type  clip_in;
   logic      vb_ff;
   span_type  span_ff;
   span_type  span_in;
   logic      rdy_a;
   logic      rdy_b;

   logic signed [18:0] s_x;
   logic signed [18:0] ax_x;
   logic signed [18:0] start0;
   logic signed [18:0] len0;
   logic signed [18:0] start1;
   logic signed [18:0] len1;
   logic signed [18:0] len2;
   logic signed [18:0] len3;
   logic [24:0]        prod;
   logic [24:0]        sum;

   always_comb begin
      s_x  = signed'(19'(in_root.res[9:0]));
      ax_x = 19'(in_side.ax);
      if (in_side.kind == cssg_pkg::SHAPE_CIRCLE) begin
         start0 = ax_x - s_x;
         len0   = s_x + s_x;
      end else begin
         start0 = ax_x;
         len0   = signed'(19'(in_side.w));
      end
      if (start0[18]) begin
         len1   = len0 + start0;
         start1 = '0;
      end else begin
         len1   = len0;
         start1 = start0;
      end
      len2 = (start1 + len1 >= COL_LIMIT) ? (COL_LIMIT - start1) : len1;
      len3 = len2[18] ? '0 : len2;

      clip_in.hit   = in_side.hit;
      clip_in.start = start1[14:0];
      clip_in.len   = len3[11:0];
      clip_in.row   = in_side.row;
      clip_in.color = in_side.color;
   end

   always_comb begin
      prod = 25'(clip_ff.row) * 25'(pitch);
      sum  = prod + 25'(clip_ff.start);
      span_in.hit    = clip_ff.hit;
      span_in.offset = clip_ff.hit ? sum[20:0] : '0;
      span_in.len    = clip_ff.hit ? clip_ff.len : '0;
      span_in.color  = clip_ff.hit ? clip_ff.color : '0;
   end

   assign rdy_b    = !vb_ff || out_ready;
   assign rdy_a    = !va_ff || rdy_b;
   assign in_ready = rdy_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (rdy_a) begin
            va_ff <= in_valid;
         end
         if (rdy_b) begin
            vb_ff <= va_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a && in_valid) begin
         clip_ff <= clip_in;
      end
      if (rdy_b && va_ff) begin
         span_ff <= span_in;
      end
   end

   assign out_valid   = vb_ff;
   assign span_valid  = span_ff.hit;
   assign span_offset = span_ff.offset;
   assign span_length = span_ff.len;
   assign span_color  = span_ff.color;

endmodule

/* dv/tb_clipped_shape_span_generator_core.sv */
// Testbench: random and directed scanline span requests checked against an in-bench predictor.
module tb_clipped_shape_span_generator_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SCR_W    = cssg_pkg::SCREEN_WIDTH_DEF;
   localparam int SCR_H    = cssg_pkg::SCREEN_HEIGHT_DEF;
   localparam int STALL_LIMIT = 4000;
   localparam logic [cssg_pkg::CSR_ADDR_W-1:0] PITCH_ADDR =
      {cssg_pkg::CSR_PITCH_IDX, {cssg_pkg::CSR_IDX_LSB{1'b0}}};

   typedef struct {
      logic               kind;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic [11:0]        w;
      logic [11:0]        h;
      logic [9:0]         r;
      logic [11:0]        row;
      logic [31:0]        color;
   } row_req_type;

   typedef struct {
      logic        hit;
      logic [20:0] offs;
      logic [11:0] len;
      logic [31:0] color;
   } span_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_type = 1'b0;
   logic signed [15:0]    req_anchor_x = '0;
   logic signed [15:0]    req_anchor_y = '0;
   logic [11:0]           req_rect_width = '0;
   logic [11:0]           req_rect_height = '0;
   logic [9:0]            req_radius = '0;
   logic [11:0]           req_row_index = '0;
   logic [31:0]           req_fill_color = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_span_valid;
   logic [20:0]           rsp_span_offset;
   logic [11:0]           rsp_span_length;
   logic [31:0]           rsp_span_color;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [cssg_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [cssg_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [cssg_pkg::CSR_DATA_W-1:0] prdata;
   logic                  pready;

   row_req_type rows_todo[$];
   span_type    spans_due[$];
   logic [12:0] pitch_cfg = cssg_pkg::PITCH_RESET;
   int          req_idle_pct = 0;
   int          rsp_idle_pct = 0;
   logic        rsp_hold = 1'b0;
   logic        req_fired = 1'b0;
   int          beats_in = 0;
   int          faults = 0;
   int          quiet_cycles = 0;

   clipped_shape_span_generator_core #(
      .SCREEN_WIDTH  (SCR_W),
      .SCREEN_HEIGHT (SCR_H)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_anchor_x    (req_anchor_x),
      .req_anchor_y    (req_anchor_y),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .req_radius      (req_radius),
      .req_row_index   (req_row_index),
      .req_fill_color  (req_fill_color),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_span_valid  (rsp_span_valid),
      .rsp_span_offset (rsp_span_offset),
      .rsp_span_length (rsp_span_length),
      .rsp_span_color  (rsp_span_color),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always #4 clock = ~clock;

   function automatic int root_floor(int n);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = 2048;
      while (hi - lo > 1) begin
         mid = (lo + hi) / 2;
         if (mid * mid <= n) lo = mid;
         else hi = mid;
      end
      return lo;
   endfunction

   function automatic span_type span_of(row_req_type q, logic [12:0] pitch);
      int          ax;
      int          ay;
      int          ii;
      int          rr;
      int          d;
      int          y;
      int          x0;
      int          n;
      logic        in_shape;
      logic [31:0] acc;
      span_type    s;
      ax = q.ax;
      ay = q.ay;
      ii = int'(q.row);
      rr = int'(q.r);
      s = '{hit: 1'b0, offs: '0, len: '0, color: '0};
      if (q.kind == cssg_pkg::SHAPE_RECT) begin
         in_shape = ii < int'(q.h);
         y = ay + ii;
         n = int'(q.w);
         x0 = ax;
      end else begin
         d = rr - ii;
         in_shape = ii < 2 * rr;
         y = ay - rr + ii;
         n = in_shape ? 2 * root_floor(rr * rr - d * d) : 0;
         x0 = ax - n / 2;
      end
      if (!in_shape || y < 0 || y >= SCR_H) return s;
      if (x0 < 0) begin
         n = n + x0;
         x0 = 0;
      end
      if (x0 + n >= SCR_W) n = SCR_W - x0;
      if (n < 0) n = 0;
      acc = 32'(y) * 32'(pitch) + 32'(x0);
      s.hit = 1'b1;
      s.offs = acc[20:0];
      s.len = n[11:0];
      s.color = q.color;
      return s;
   endfunction

   function automatic row_req_type rand_row();
      row_req_type q;
      int          pick;
      int          yt;
      q.kind = 1'($urandom_range(0, 1));
      q.ax = 16'($urandom);
      q.ay = 16'($urandom);
      q.w = 12'($urandom);
      q.h = 12'($urandom);
      q.r = 10'($urandom);
      q.row = 12'($urandom);
      q.color = $urandom;
      pick = $urandom_range(0, 99);
      if (pick >= 12) begin
         yt = $urandom_range(0, 360) - 20;
         if (q.kind == cssg_pkg::SHAPE_RECT) begin
            if ($urandom_range(0, 3) != 0) q.w = 12'($urandom_range(0, 600));
            q.h = 12'($urandom_range(1, ($urandom_range(0, 7) == 0) ? 4095 : 400));
            q.row = (pick < 20) ? 12'($urandom_range(q.h, 4095))
                                : 12'($urandom_range(0, q.h - 1));
            q.ax = 16'($urandom_range(0, 1300) - 400);
            q.ay = 16'(yt - int'(q.row));
         end else begin
            q.r = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 1023))
                                              : 10'($urandom_range(0, 250));
            if (q.r != 0 && pick >= 20) q.row = 12'($urandom_range(0, 2 * int'(q.r) - 1));
            else q.row = 12'($urandom_range(2 * int'(q.r), 4095));
            q.ax = 16'($urandom_range(0, 1000) - 260);
            q.ay = 16'(yt + int'(q.r) - int'(q.row));
         end
      end
      return q;
   endfunction

   task automatic push_row(logic kind, int ax, int ay, int w, int h, int r, int row,
                           logic [31:0] color);
      row_req_type q;
      q.kind = kind;
      q.ax = 16'(ax);
      q.ay = 16'(ay);
      q.w = 12'(w);
      q.h = 12'(h);
      q.r = 10'(r);
      q.row = 12'(row);
      q.color = color;
      rows_todo.push_back(q);
   endtask

   task automatic flag_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         faults++;
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   task automatic read_pitch();
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b0;
      penable <= 1'b0;
      paddr <= PITCH_ADDR;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      flag_field("pitch readback", 32'(pitch_cfg), prdata);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_pitch(logic [12:0] value);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= PITCH_ADDR;
      pwdata <= 32'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      pitch_cfg = value;
      read_pitch();
   endtask

   task automatic drain();
      while (rows_todo.size() != 0 || req_valid || spans_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic push_random(int count);
      repeat (count) rows_todo.push_back(rand_row());
   endtask

   // drive the request and result channels
   always @(negedge clock) begin
      row_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (!req_valid || req_fired) begin
            if (rows_todo.size() != 0 && $urandom_range(0, 99) >= req_idle_pct) begin
               nxt = rows_todo.pop_front();
               req_valid <= 1'b1;
               req_type <= nxt.kind;
               req_anchor_x <= nxt.ax;
               req_anchor_y <= nxt.ay;
               req_rect_width <= nxt.w;
               req_rect_height <= nxt.h;
               req_radius <= nxt.r;
               req_row_index <= nxt.row;
               req_fill_color <= nxt.color;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= !rsp_hold && ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   // predict on each request beat, check each result beat
   always @(posedge clock) begin
      row_req_type seen;
      span_type    want;
      if (reset) begin
         req_fired = 1'b0;
      end else begin
         req_fired = req_valid && req_ready;
         if (req_fired) begin
            seen.kind = req_type;
            seen.ax = req_anchor_x;
            seen.ay = req_anchor_y;
            seen.w = req_rect_width;
            seen.h = req_rect_height;
            seen.r = req_radius;
            seen.row = req_row_index;
            seen.color = req_fill_color;
            spans_due.push_back(span_of(seen, pitch_cfg));
            beats_in++;
         end
         if (rsp_valid && rsp_ready) begin
            if (spans_due.size() == 0) begin
               faults++;
               $display("%0t: unexpected span beat, expected none actual offset %0h length %0h",
                        $time, rsp_span_offset, rsp_span_length);
            end else begin
               want = spans_due.pop_front();
               flag_field("span_valid", 32'(want.hit), 32'(rsp_span_valid));
               flag_field("span_offset", 32'(want.offs), 32'(rsp_span_offset));
               flag_field("span_length", 32'(want.len), 32'(rsp_span_length));
               flag_field("span_color", want.color, rsp_span_color);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable && pready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("clipped_shape_span_generator_core verification failed");
         $finish;
      end
   end

   // hold off the result side long enough to back up the pipeline
   initial begin
      wait (beats_in >= 80);
      rsp_hold = 1'b1;
      repeat (64) @(posedge clock);
      rsp_hold = 1'b0;
   end

   initial begin
      logic [12:0] spread[3];
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      read_pitch();

      req_idle_pct = 29;
      rsp_idle_pct = 69;
      push_row(cssg_pkg::SHAPE_RECT, 10, 20, 100, 5, 7, 2, 32'hDEADBEEF);
      push_row(cssg_pkg::SHAPE_RECT, 10, 20, 100, 5, 0, 5, 32'hFFFFFFFF);
      push_row(cssg_pkg::SHAPE_RECT, 10, 20, 100, 0, 0, 0, 32'h12345678);
      push_row(cssg_pkg::SHAPE_RECT, 10, -10, 100, 9, 0, 3, 32'h1);
      push_row(cssg_pkg::SHAPE_RECT, 10, 319, 100, 9, 0, 1, 32'h2);
      push_row(cssg_pkg::SHAPE_RECT, 0, 0, 480, 1, 1023, 0, 32'hA5A5A5A5);
      push_row(cssg_pkg::SHAPE_RECT, 479, 300, 1, 20, 0, 19, 32'h5A5A5A5A);
      push_row(cssg_pkg::SHAPE_RECT, -50, 40, 100, 9, 0, 4, 32'h3);
      push_row(cssg_pkg::SHAPE_RECT, -200, 40, 100, 9, 0, 4, 32'h4);
      push_row(cssg_pkg::SHAPE_RECT, 400, 41, 200, 9, 0, 4, 32'h5);
      push_row(cssg_pkg::SHAPE_RECT, 1000, 42, 10, 9, 0, 4, 32'h6);
      push_row(cssg_pkg::SHAPE_RECT, -32768, -4000, 4095, 4095, 0, 4094, 32'h7);
      push_row(cssg_pkg::SHAPE_RECT, 32767, 32767, 4095, 4095, 1023, 4095, 32'h0);
      push_row(cssg_pkg::SHAPE_CIRCLE, 100, 100, 4095, 4095, 0, 0, 32'h8);
      push_row(cssg_pkg::SHAPE_CIRCLE, 240, 160, 4095, 4095, 1023, 1023, 32'h9);
      push_row(cssg_pkg::SHAPE_CIRCLE, 100, 100, 0, 0, 10, 0, 32'hA);
      push_row(cssg_pkg::SHAPE_CIRCLE, 100, 100, 0, 0, 10, 19, 32'hB);
      push_row(cssg_pkg::SHAPE_CIRCLE, 100, 100, 0, 0, 10, 20, 32'hC);
      push_row(cssg_pkg::SHAPE_CIRCLE, -3, 50, 7, 7, 5, 5, 32'hFFFFFFFF);
      push_row(cssg_pkg::SHAPE_CIRCLE, 240, 160, 0, 0, 1023, 4095, 32'h0);
      push_row(cssg_pkg::SHAPE_CIRCLE, 32767, -32768, 0, 0, 1023, 2045, 32'hD);
      push_row(cssg_pkg::SHAPE_CIRCLE, 470, 100, 0, 0, 300, 300, 32'hE);
      push_row(cssg_pkg::SHAPE_CIRCLE, 2000, 200, 0, 0, 50, 50, 32'hF);
      drain();

      set_pitch(13'd1);
      push_random(370);
      drain();

      req_idle_pct = 69;
      rsp_idle_pct = 29;
      set_pitch(13'h1FFF);
      push_random(185);
      drain();
      push_random(185);
      drain();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      spread[0] = 13'd0;
      spread[1] = 13'd4096;
      spread[2] = 13'($urandom_range(2, 8190));
      foreach (spread[k]) begin
         set_pitch(spread[k]);
         push_random(120);
         drain();
      end

      repeat (24) @(posedge clock);
      if (faults == 0)
         $display("clipped_shape_span_generator_core verification clean");
      else
         $display("clipped_shape_span_generator_core verification failed");
      $finish;
   end

endmodule

/* files.f */
+incdir+src
src/cssg_pkg.sv
src/cssg_prep.sv
src/cssg_sqrt.sv
src/cssg_clip.sv
src/clipped_shape_span_generator_core.sv
dv/tb_clipped_shape_span_generator_core.sv
